// ===== rtl/battery_level_median_slew_filter_assert.svh =====
// Assertion macros shared by the battery level filter modules.
`ifndef BATTERY_LEVEL_MEDIAN_SLEW_FILTER_ASSERT_SVH
`define BATTERY_LEVEL_MEDIAN_SLEW_FILTER_ASSERT_SVH

// Check a same-cycle implication on the rising clock edge, off during reset.
`define BLMSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication that lands in the next cycle, off during reset.
`define BLMSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/blmsf_pkg.sv =====
// Shared constants, types and helpers of the battery level filter.
package blmsf_pkg;

  // Sample ring geometry
  localparam int SAMPLE_DEPTH = 8;
  localparam int SLOT_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1);

  // Level and time widths
  localparam int LVL_W  = 7;
  localparam int BIT_W  = 3;
  localparam int TIME_W = 63;
  localparam int HOLD_W = 32;
  localparam logic [LVL_W-1:0] LVL_MAX = 7'd100;

  // Command codes
  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_WAKE   = 2'd1,
    CMD_UNPLUG = 2'd2,
    CMD_FULL   = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam logic REG_UNPLUG_HOLD = 1'b0;
  localparam logic REG_WAKE_SETTLE = 1'b1;

  // Control from the sequencer to the rank unit
  typedef struct packed {
    logic wr;
    logic start;
  } rank_ctl_t;

  // True when now falls inside a no-drop window opened at stored
  function automatic logic in_window(input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] stored,
                                     input logic [HOLD_W-1:0] len);
    logic [TIME_W:0] diff;
    diff = {1'b0, now} - {1'b0, stored};
    in_window = (stored != '0) &&
                (diff[TIME_W] || (diff[TIME_W-1:0] < {{(TIME_W-HOLD_W){1'b0}}, len}));
  endfunction

endpackage

// ===== rtl/blmsf_rank.sv =====
// Sample ring and bitwise median search unit, one result bit per cycle.
module blmsf_rank import blmsf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  rank_ctl_t        ctl,
  input  logic [LVL_W-1:0] wr_data,
  output logic [LVL_W-1:0] median,
  output logic             done
);

  logic [LVL_W-1:0]  ring [SAMPLE_DEPTH];
  logic [SLOT_W-1:0] write_slot;
  logic [CNT_W-1:0]  fill_count;
  logic [LVL_W-1:0]  ans;
  logic [BIT_W-1:0]  bit_idx;
  logic              busy;
  logic [LVL_W-1:0]  trial;
  logic [CNT_W-1:0]  below;
  logic [CNT_W-1:0]  rank_k;

  // Count held samples below the trial value
  always_comb begin
    trial  = ans | (LVL_W'(1) << bit_idx);
    rank_k = fill_count >> 1;
    below  = '0;
    for (int i = 0; i < SAMPLE_DEPTH; i++) begin
      if ((CNT_W'(i) < fill_count) && (ring[i] < trial)) begin
        below = below + CNT_W'(1);
      end
    end
  end

  // Write the ring; no reset, entries past fill_count are never counted
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      ring[write_slot] <= wr_data;
    end
  end

  // Advance ring pointers and step the search
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
      busy       <= 1'b0;
      done       <= 1'b0;
      bit_idx    <= '0;
      ans        <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.wr) begin
        write_slot <= (write_slot == SLOT_W'(SAMPLE_DEPTH - 1)) ? '0 : write_slot + 1'b1;
        if (fill_count < CNT_W'(SAMPLE_DEPTH)) begin
          fill_count <= fill_count + 1'b1;
        end
      end
      if (ctl.start) begin
        busy    <= 1'b1;
        ans     <= '0;
        bit_idx <= BIT_W'(LVL_W - 1);
      end else if (busy) begin
        if (below <= rank_k) begin
          ans <= trial;
        end
        if (bit_idx == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          bit_idx <= bit_idx - 1'b1;
        end
      end
    end
  end

  assign median = ans;

  `include "battery_level_median_slew_filter_assert.svh"

  `BLMSF_ASSERT_NOW(a_median_range, done, median <= LVL_MAX, "median above full scale")

endmodule

// ===== rtl/battery_level_median_slew_filter.sv =====
// Battery level filter: upper median over recent samples, then a one-step slew.
//
// Input channel: in_valid / in_stall carry one command beat (cmd, time_ms,
// sample_pct, woke_from_sleep, retained_ok, saved_pct, flag). Output
// channel: out_valid / out_stall carry one result beat (display_level,
// clamped_level) for every command. Configuration: cfg_we writes cfg_data
// into the register at cfg_index (0 unplug hold, 1 wake settle); the user must
// do so only while idle, as the block does not enforce it.
// A record command runs two window checks on the shared 63-bit subtract/compare
// (unplug window, then wake window) while the bitwise median search, started
// with the first check, finds one result bit per cycle over all held samples;
// the slew update follows once the search is done. Other commands go straight
// to their result. One command is worked on at a time; in_stall stays high
// from acceptance until the result is loaded into the output register.
//
// A finished result waits in the output register while out_stall is high;
// the next command is taken meanwhile, and its result waits until the slot
// frees. Reset clears the ring fill, the time stamps, the latch and shows -1.
module battery_level_median_slew_filter import blmsf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               cmd,
  input  logic [TIME_W-1:0]        time_ms,
  input  logic signed [15:0]       sample_pct,
  input  logic                     woke_from_sleep,
  input  logic                     retained_ok,
  input  logic signed [15:0]       saved_pct,
  input  logic                     flag,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [7:0]        display_level,
  output logic signed [7:0]        clamped_level,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [HOLD_W-1:0]        cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WIN0 = 5'b00010,
    S_WIN1 = 5'b00100,
    S_WAIT = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [HOLD_W-1:0] unplug_hold;
  logic [HOLD_W-1:0] wake_settle;
  logic [TIME_W-1:0] wake_time;
  logic [TIME_W-1:0] unplug_time;
  logic              full_latch;
  logic signed [7:0] shown_level;
  logic              shown_valid;
  logic signed [7:0] last_clamped;
  logic [TIME_W-1:0] cur_time;
  logic              use_ret;
  logic [LVL_W-1:0]  ret_lvl;
  logic              is_record;
  logic              hold;

  logic              in_acc;
  logic              fire;
  logic [LVL_W-1:0]  clamp_val;
  logic              ret_in_range;
  rank_ctl_t         rank_ctl;
  logic [LVL_W-1:0]  rank_median;
  logic              rank_done;
  logic              win_hit;
  logic signed [7:0] tgt;
  logic signed [7:0] base;
  logic signed [7:0] lim;
  logic signed [7:0] shown_next;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign fire     = (state == S_FIN) && (!out_valid || !out_stall);

  // Clamp the raw level and qualify the retained level
  always_comb begin
    if (sample_pct[15]) begin
      clamp_val = '0;
    end else if (sample_pct > 16'sd100) begin
      clamp_val = LVL_MAX;
    end else begin
      clamp_val = sample_pct[LVL_W-1:0];
    end
    ret_in_range = !saved_pct[15] && (saved_pct <= 16'sd100);
  end

  // Drive the rank unit: write on a record beat, search the next cycle
  always_comb begin
    rank_ctl.wr    = in_acc && (cmd_t'(cmd) == CMD_RECORD);
    rank_ctl.start = (state == S_WIN0);
  end

  blmsf_rank u_rank (
    .clk     (clk),
    .rst     (rst),
    .ctl     (rank_ctl),
    .wr_data (clamp_val),
    .median  (rank_median),
    .done    (rank_done)
  );

  // Shared window check: unplug window first, then wake window
  always_comb begin
    if (state == S_WIN0) begin
      win_hit = in_window(cur_time, unplug_time, unplug_hold);
    end else begin
      win_hit = in_window(cur_time, wake_time, wake_settle);
    end
  end

  // Pick the first shown value, hold off drops, then step one
  always_comb begin
    tgt  = full_latch ? $signed({1'b0, LVL_MAX}) : $signed({1'b0, rank_median});
    if (shown_valid) begin
      base = shown_level;
    end else if (use_ret) begin
      base = $signed({1'b0, ret_lvl});
    end else begin
      base = tgt;
    end
    lim = (hold && (tgt < base)) ? base : tgt;
    if (lim > base) begin
      shown_next = base + 8'sd1;
    end else if (lim < base) begin
      shown_next = base - 8'sd1;
    end else begin
      shown_next = base;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = (cmd_t'(cmd) == CMD_RECORD) ? S_WIN0 : S_FIN;
        end
      end
      S_WIN0: state_next = S_WIN1;
      S_WIN1: state_next = S_WAIT;
      S_WAIT: begin
        if (rank_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      unplug_hold  <= '0;
      wake_settle  <= '0;
      wake_time    <= '0;
      unplug_time  <= '0;
      full_latch   <= 1'b0;
      shown_level  <= -8'sd1;
      shown_valid  <= 1'b0;
      last_clamped <= -8'sd1;
      out_valid    <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= fire || (out_valid && out_stall);
      if (cfg_we) begin
        if (cfg_index == REG_UNPLUG_HOLD) begin
          unplug_hold <= cfg_data;
        end else if (cfg_index == REG_WAKE_SETTLE) begin
          wake_settle <= cfg_data;
        end
      end
      if (in_acc) begin
        case (cmd_t'(cmd))
          CMD_RECORD: last_clamped <= $signed({1'b0, clamp_val});
          CMD_WAKE:   wake_time    <= time_ms;
          CMD_UNPLUG: unplug_time  <= time_ms;
          CMD_FULL:   full_latch   <= flag;
          default:    full_latch   <= full_latch;
        endcase
      end
      if (fire && is_record) begin
        shown_level <= shown_next;
        shown_valid <= 1'b1;
      end
    end
  end

  // Hold the beat fields and window result while the item is worked on
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_time  <= time_ms;
      use_ret   <= woke_from_sleep && retained_ok && ret_in_range;
      ret_lvl   <= saved_pct[LVL_W-1:0];
      is_record <= (cmd_t'(cmd) == CMD_RECORD);
    end
    if (state == S_WIN0) begin
      hold <= win_hit;
    end else if (state == S_WIN1) begin
      hold <= hold || win_hit;
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (fire) begin
      display_level <= is_record ? shown_next : shown_level;
      clamped_level <= last_clamped;
    end
  end

  `include "battery_level_median_slew_filter_assert.svh"

  `BLMSF_ASSERT_NOW(a_done_in_wait, rank_done, state == S_WAIT, "median done outside wait")
  `BLMSF_ASSERT_NEXT(a_fire_loads, fire, out_valid, "result not presented after load")
  `BLMSF_ASSERT_NOW(a_disp_range, out_valid, (display_level >= -8'sd1) && (display_level <= 8'sd100), "display level out of range")

endmodule
